/* rtl/prime_square_counter_unit_macros.svh */
// Assertion macros used by the checker file of the prime square counter.
`ifndef PRIME_SQUARE_COUNTER_UNIT_MACROS_SVH
`define PRIME_SQUARE_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define PSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under an active-low reset.
`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/psc_pkg.sv */
// Package with the constants and types of the prime square counter.
`default_nettype none
package psc_pkg;
	localparam int unsigned SIEVE_LIMIT_DEF = 1048576;
	localparam int unsigned IN_W = 41;
	localparam int unsigned OUT_W = 17;
	localparam int unsigned SQ_W = 43;
	localparam int unsigned ROOT_W = 22;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MARK,
		ST_CNT_RD,
		ST_CNT_WR,
		ST_SQ_START,
		ST_SQ_WAIT,
		ST_LOOK_N,
		ST_LOOK_K,
		ST_FIN
	} psc_state_t;
endpackage
`default_nettype wire

/* rtl/psc_if.sv */
// Handshake interfaces for the query and result channels.
`default_nettype none
interface psc_query_if;
	logic valid;
	logic ready;
	logic [psc_pkg::IN_W-1:0] upper_bound_n;
	logic [psc_pkg::IN_W-1:0] lower_bound_k;
	modport source(output valid, upper_bound_n, lower_bound_k, input ready);
	modport sink(input valid, upper_bound_n, lower_bound_k, output ready);
endinterface

interface psc_result_if;
	logic valid;
	logic ready;
	logic [psc_pkg::OUT_W-1:0] count_up_to_n;
	logic [psc_pkg::OUT_W-1:0] excess_over_k;
	modport source(output valid, count_up_to_n, excess_over_k, input ready);
	modport sink(input valid, count_up_to_n, excess_over_k, output ready);
endinterface
`default_nettype wire

/* rtl/psc_isqrt.sv */
// Integer square root, one radix-4 digit per cycle.
`default_nettype none
module psc_isqrt (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [psc_pkg::IN_W-1:0]    value,
	output logic                             done,
	output logic [psc_pkg::ROOT_W-1:0]       root
);
	import psc_pkg::*;

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] root_q;
	logic [SQ_W-1:0] bit_q;
	logic            run_q;
	logic            done_q;
	logic [SQ_W-1:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= SQ_W'(value);
			root_q <= '0;
			bit_q  <= SQ_W'(1) << (SQ_W - 1);
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q    <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[ROOT_W-1:0];
endmodule
`default_nettype wire

/* rtl/prime_square_counter_unit.sv */
// Top level of the prime square counter: sieve build, lookup and result control.
//
// The query channel carries bounds n and k; the result channel returns the
// number of primes whose square is at most n and that count minus the count
// for k, floored at zero. One result transaction follows every query.
// After reset the tables are empty. The first query first clears the composite
// bitmap, sieves it (marking the multiples of each prime up to the square root
// of SIEVE_LIMIT), and then builds the running prime count. Queries are not
// accepted during this build.
// Each query then runs from acceptance to a valid result through two square
// roots on the shared bit-serial unit (each a start, the digit steps and a
// done), two reads of the count memory on its single read port, and a finish
// state. A new query is taken only after the last result is registered.
// One query is in work at a time. A finished result waits in the output
// register while the receiver stalls, and the next query may already run;
// it completes once the output register is free again.
`default_nettype none
module prime_square_counter_unit #(
	parameter int unsigned SIEVE_LIMIT = psc_pkg::SIEVE_LIMIT_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	psc_query_if.sink      query,
	psc_result_if.source   result
);
	import psc_pkg::*;

	localparam int unsigned ADDR_W = $clog2(SIEVE_LIMIT + 1);
	localparam int unsigned CNT_W  = ADDR_W;
	localparam int unsigned CMP_W  = (ADDR_W > ROOT_W) ? ADDR_W + 1 : ROOT_W + 1;
	localparam int unsigned DEPTH  = SIEVE_LIMIT + 1;

	psc_state_t state_q, state_d;

	logic              comp_mem [DEPTH];
	logic [CNT_W-1:0]  cnt_mem [DEPTH];
	logic              comp_rd_q;
	logic [CNT_W-1:0]  cnt_rd_q;

	logic              comp_we, comp_wd, cnt_we;
	logic [ADDR_W-1:0] comp_waddr, comp_raddr, cnt_raddr;

	logic [ADDR_W-1:0] a_q, i_q;
	logic [ADDR_W:0]   j_q, j_next;
	logic [CNT_W-1:0]  tally_q, tally_next;
	logic [2*ADDR_W-1:0] i_sq;
	logic              built_q, sel_q, res_valid_q;
	logic [IN_W-1:0]   n_q, k_q;
	logic [ROOT_W-1:0] rn_q, rk_q, root;
	logic [CNT_W-1:0]  cn_q;
	logic [OUT_W-1:0]  res_cnt_q, res_exc_q;
	logic [CNT_W-1:0]  diff;
	logic [31:0]       cn32, diff32;
	logic              accept, out_free;
	logic              sq_start, sq_done;

	function automatic logic [ADDR_W-1:0] clamp(input logic [ROOT_W-1:0] r);
		logic [CMP_W-1:0] rx;
		rx = CMP_W'(r);
		if (rx > CMP_W'(SIEVE_LIMIT)) begin
			return ADDR_W'(SIEVE_LIMIT);
		end
		return rx[ADDR_W-1:0];
	endfunction

	psc_isqrt u_isqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.value (sel_q ? k_q : n_q),
		.done  (sq_done),
		.root  (root)
	);

	assign accept     = query.valid && query.ready;
	assign out_free   = !res_valid_q || result.ready;
	assign i_sq       = (2*ADDR_W)'(i_q) * (2*ADDR_W)'(i_q);
	assign j_next     = j_q + (ADDR_W+1)'(i_q);
	assign tally_next = tally_q + CNT_W'(!comp_rd_q);
	assign diff       = (cn_q >= cnt_rd_q) ? cn_q - cnt_rd_q : '0;
	assign cn32       = 32'(cn_q);
	assign diff32     = 32'(diff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		query.ready = 1'b0;
		sq_start    = 1'b0;
		comp_we     = 1'b0;
		comp_wd     = 1'b0;
		comp_waddr  = a_q;
		comp_raddr  = a_q;
		cnt_we      = 1'b0;
		cnt_raddr   = clamp(rn_q);
		unique case (state_q)
			ST_IDLE: begin
				query.ready = 1'b1;
				if (query.valid) begin
					state_d = built_q ? ST_SQ_START : ST_CLR;
				end
			end
			ST_CLR: begin
				comp_we = 1'b1;
				comp_wd = (a_q < ADDR_W'(2));
				if (a_q == ADDR_W'(SIEVE_LIMIT)) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				comp_raddr = i_q;
				state_d = (i_sq > (2*ADDR_W)'(SIEVE_LIMIT)) ? ST_CNT_RD : ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				state_d = comp_rd_q ? ST_SCAN_RD : ST_MARK;
			end
			ST_MARK: begin
				comp_we    = 1'b1;
				comp_wd    = 1'b1;
				comp_waddr = j_q[ADDR_W-1:0];
				if (j_next > (ADDR_W+1)'(SIEVE_LIMIT)) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_CNT_RD: begin
				state_d = ST_CNT_WR;
			end
			ST_CNT_WR: begin
				cnt_we  = 1'b1;
				state_d = (a_q == ADDR_W'(SIEVE_LIMIT)) ? ST_SQ_START : ST_CNT_RD;
			end
			ST_SQ_START: begin
				sq_start = 1'b1;
				state_d = ST_SQ_WAIT;
			end
			ST_SQ_WAIT: begin
				if (sq_done) begin
					state_d = sel_q ? ST_LOOK_N : ST_SQ_START;
				end
			end
			ST_LOOK_N: begin
				state_d = ST_LOOK_K;
			end
			ST_LOOK_K: begin
				cnt_raddr = clamp(rk_q);
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cnt_raddr = clamp(rk_q);
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (comp_we) begin
			comp_mem[comp_waddr] <= comp_wd;
		end
		comp_rd_q <= comp_mem[comp_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[a_q] <= tally_next;
		end
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CNT_WR && a_q == ADDR_W'(SIEVE_LIMIT)) begin
				built_q <= 1'b1;
			end
			if (state_q == ST_FIN && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				a_q   <= '0;
				sel_q <= 1'b0;
				if (accept) begin
					n_q <= query.upper_bound_n;
					k_q <= query.lower_bound_k;
				end
			end
			ST_CLR: begin
				a_q <= a_q + ADDR_W'(1);
				i_q <= ADDR_W'(2);
			end
			ST_SCAN_RD: begin
				a_q     <= '0;
				tally_q <= '0;
				j_q     <= (ADDR_W+1)'(i_sq);
			end
			ST_SCAN_CHK: begin
				if (comp_rd_q) begin
					i_q <= i_q + ADDR_W'(1);
				end
			end
			ST_MARK: begin
				j_q <= j_next;
				if (j_next > (ADDR_W+1)'(SIEVE_LIMIT)) begin
					i_q <= i_q + ADDR_W'(1);
				end
			end
			ST_CNT_RD: begin
			end
			ST_CNT_WR: begin
				tally_q <= tally_next;
				a_q     <= a_q + ADDR_W'(1);
				sel_q   <= 1'b0;
			end
			ST_SQ_START: begin
			end
			ST_SQ_WAIT: begin
				if (sq_done) begin
					if (sel_q) begin
						rk_q <= root;
					end else begin
						rn_q  <= root;
						sel_q <= 1'b1;
					end
				end
			end
			ST_LOOK_N: begin
			end
			ST_LOOK_K: begin
				cn_q <= cnt_rd_q;
			end
			ST_FIN: begin
				if (out_free) begin
					res_cnt_q <= cn32[OUT_W-1:0];
					res_exc_q <= diff32[OUT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid         = res_valid_q;
	assign result.count_up_to_n = res_cnt_q;
	assign result.excess_over_k = res_exc_q;
endmodule
`default_nettype wire

/* rtl/psc_checker.sv */
// Port-level checker for the prime square counter, bound to the top level.
`default_nettype none
`include "prime_square_counter_unit_macros.svh"
module psc_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      q_valid,
	input wire logic                      q_ready,
	input wire logic                      r_valid,
	input wire logic                      r_ready,
	input wire logic [psc_pkg::OUT_W-1:0] r_count,
	input wire logic [psc_pkg::OUT_W-1:0] r_excess
);
	import psc_pkg::*;

	`PSC_ASSERT_NEXT(a_hold, clk, arst_n, r_valid && !r_ready, r_valid && $stable(r_count) && $stable(r_excess), "result changed while stalled")
	`PSC_ASSERT_NOW(a_excess, clk, arst_n, r_valid, r_excess <= r_count, "excess above count")
	`PSC_ASSERT_NEXT(a_busy, clk, arst_n, q_valid && q_ready, !q_ready, "query taken while busy")
endmodule

bind prime_square_counter_unit psc_checker u_psc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.q_valid (query.valid),
	.q_ready (query.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_count (result.count_up_to_n),
	.r_excess(result.excess_over_k)
);
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the prime square counter with random bounds and handshake stalls.
`timescale 1ns / 1ps

module testbench;
	import psc_pkg::*;

	localparam int unsigned LIMIT = SIEVE_LIMIT_DEF;
	localparam longint unsigned BOUND_MAX = 64'd1 << 40;
	localparam int RANDOM_QUERIES = 1730;
	localparam int WATCHDOG_CYCLES = 20000000;

	typedef struct packed {
		logic [OUT_W-1:0] count_up_to_n;
		logic [OUT_W-1:0] excess_over_k;
	} prime_counts_t;

	class prime_count_board;
		int unsigned primes_upto[];
		prime_counts_t pending[$];
		int failures;

		function new();
			byte composite[];
			int unsigned tally;
			longint unsigned i;
			longint unsigned j;
			composite = new[LIMIT + 1];
			primes_upto = new[LIMIT + 1];
			failures = 0;
			tally = 0;
			composite[0] = 1;
			composite[1] = 1;
			for (i = 2; i * i <= LIMIT; i++) begin
				if (composite[i] == 0) begin
					for (j = i * i; j <= LIMIT; j += i)
						composite[j] = 1;
				end
			end
			for (i = 0; i <= LIMIT; i++) begin
				if (composite[i] == 0)
					tally++;
				primes_upto[i] = tally;
			end
		endfunction

		function longint unsigned floor_sqrt(longint unsigned v);
			longint unsigned root;
			longint unsigned b;
			root = 0;
			b = 64'd1 << 42;
			while (b > v)
				b >>= 2;
			while (b != 0) begin
				if (v >= root + b) begin
					v -= root + b;
					root = (root >> 1) + b;
				end else begin
					root >>= 1;
				end
				b >>= 2;
			end
			return root;
		endfunction

		function int unsigned primes_squared_within(logic [IN_W-1:0] bound);
			longint unsigned r;
			r = floor_sqrt(64'(bound));
			if (r > LIMIT)
				r = LIMIT;
			return primes_upto[r];
		endfunction

		function void note_query(logic [IN_W-1:0] n, logic [IN_W-1:0] k);
			int unsigned cn;
			int unsigned ck;
			prime_counts_t e;
			cn = primes_squared_within(n);
			ck = primes_squared_within(k);
			e.count_up_to_n = cn[OUT_W-1:0];
			e.excess_over_k = (cn >= ck) ? OUT_W'(cn - ck) : '0;
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(logic [OUT_W-1:0] cnt, logic [OUT_W-1:0] exc);
			prime_counts_t e;
			if (pending.size() == 0) begin
				$error("unexpected result transaction: count_up_to_n %0d excess_over_k %0d",
					cnt, exc);
				failures++;
				return;
			end
			e = pending.pop_front();
			if (cnt !== e.count_up_to_n) begin
				$error("count_up_to_n expected %0d actual %0d", e.count_up_to_n, cnt);
				failures++;
			end
			if (exc !== e.excess_over_k) begin
				$error("excess_over_k expected %0d actual %0d", e.excess_over_k, exc);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int idle_cycles = 0;
	prime_count_board board;

	psc_query_if query_ch();
	psc_result_if result_ch();

	prime_square_counter_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.query(query_ch),
		.result(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 60)
			return 0;
		if (sel < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [IN_W-1:0] random_bound();
		longint unsigned v;
		longint unsigned r;
		int w;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				w = $urandom_range(1, 40);
				v = {$urandom, $urandom};
				v &= (64'd1 << w) - 1;
			end
			4, 5, 6: begin
				r = 64'($urandom_range(0, LIMIT));
				v = r * r;
				case ($urandom_range(0, 2))
					0: if (v > 0) v = v - 1;
					1: v = v + 1;
					default: ;
				endcase
			end
			7: v = 64'($urandom_range(0, 20));
			8: v = BOUND_MAX - 64'($urandom_range(0, 3));
			default: v = {$urandom, $urandom} & (BOUND_MAX - 1);
		endcase
		if (v > BOUND_MAX)
			v = BOUND_MAX;
		return v[IN_W-1:0];
	endfunction

	task automatic send_query(logic [IN_W-1:0] n, logic [IN_W-1:0] k);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			query_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		query_ch.valid = 1'b1;
		query_ch.upper_bound_n = n;
		query_ch.lower_bound_k = k;
		do
			@(posedge clk);
		while (!query_ch.ready);
		board.note_query(n, k);
		@(negedge clk);
	endtask

	initial begin
		int unsigned stall;
		result_ch.ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				stall--;
			end else begin
				result_ch.ready = 1'b1;
				case ($urandom_range(0, 19))
					0, 1, 2: stall = $urandom_range(1, 3);
					3: stall = $urandom_range(10, 60);
					4: stall = 0;
					default: stall = 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				board.check_result(result_ch.count_up_to_n, result_ch.excess_over_k);
			if ((query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		logic [IN_W-1:0] near_top;
		board = new();
		arst_n = 1'b0;
		query_ch.valid = 1'b0;
		query_ch.upper_bound_n = '0;
		query_ch.lower_bound_k = '0;
		near_top = IN_W'(BOUND_MAX - 1);
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_query('0, '0);
		send_query(3, 0);
		send_query(4, 0);
		send_query(8, 9);
		send_query(9, 4);
		send_query(24, 25);
		send_query(25, 3);
		send_query(IN_W'(BOUND_MAX), 0);
		send_query(IN_W'(BOUND_MAX), IN_W'(BOUND_MAX));
		send_query(0, IN_W'(BOUND_MAX));
		send_query(near_top, 100);
		send_query(IN_W'(64'd1048575 * 64'd1048575), IN_W'(64'd1048573 * 64'd1048573 - 1));
		send_query(IN_W'(64'd1048573 * 64'd1048573), 0);
		send_query(1000000, 999999);
		send_query(IN_W'(64'h155_5555_5555), IN_W'(64'h0AA_AAAA_AAAA));
		send_query(IN_W'(64'h0AA_AAAA_AAAA), IN_W'(64'h155_5555_5555));
		send_query(1, IN_W'(BOUND_MAX));
		send_query(48, 49);

		for (int q = 0; q < RANDOM_QUERIES; q++)
			send_query(random_bound(), random_bound());
		query_ch.valid = 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (board.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
